// ===== src/qvr_pkg.sv =====
package qvr_pkg;

  // Default number of fraction bits of the quaternion components.
  localparam int unsigned FracBitsDef = 14;

  // Field and datapath widths.
  localparam int unsigned InW    = 16;
  localparam int unsigned MidW   = 20;
  localparam int unsigned OutW   = 16;
  localparam int unsigned ProdAW = 2 * InW;
  localparam int unsigned SumAW  = ProdAW + 3;
  localparam int unsigned ProdBW = MidW + InW;
  localparam int unsigned SumBW  = ProdBW + 4;

  // Number of partial products in each Hamilton product.
  localparam int unsigned NumProd = 12;

  typedef logic signed [InW-1:0]    in_t;
  typedef logic signed [MidW-1:0]   mid_t;
  typedef logic signed [OutW-1:0]   out_t;
  typedef logic signed [ProdAW-1:0] prod_a_t;
  typedef logic signed [SumAW-1:0]  sum_a_t;
  typedef logic signed [ProdBW-1:0] prod_b_t;
  typedef logic signed [SumBW-1:0]  sum_b_t;

  // Saturation bounds, sign-extended to the width of the sums they limit.
  localparam sum_a_t MidMaxA = sum_a_t'((64'sd1 <<< (MidW - 1)) - 64'sd1);
  localparam sum_a_t MidMinA = sum_a_t'(-(64'sd1 <<< (MidW - 1)));
  localparam sum_b_t OutMaxB = sum_b_t'((64'sd1 <<< (OutW - 1)) - 64'sd1);
  localparam sum_b_t OutMinB = sum_b_t'(-(64'sd1 <<< (OutW - 1)));

  typedef struct packed {
    in_t x;
    in_t y;
    in_t z;
    in_t w;
  } quat_t;

  typedef struct packed {
    in_t x;
    in_t y;
    in_t z;
  } vec_t;

  typedef struct packed {
    mid_t x;
    mid_t y;
    mid_t z;
    mid_t w;
  } mid_quat_t;

  typedef struct packed {
    out_t x;
    out_t y;
    out_t z;
  } res_t;

  typedef struct packed {
    mid_t val;
    logic sat;
  } mid_sat_t;

  typedef struct packed {
    out_t val;
    logic sat;
  } out_sat_t;

  // Round half up, drop the fraction bits and saturate to the middle width.
  function automatic mid_sat_t round_sat_mid(sum_a_t s, int unsigned frac);
    sum_a_t   half;
    sum_a_t   r;
    mid_sat_t res;
    half = sum_a_t'(1) <<< (frac - 1);
    r    = (s + half) >>> frac;
    if (r > MidMaxA) begin
      res.val = MidMaxA[MidW-1:0];
      res.sat = 1'b1;
    end else if (r < MidMinA) begin
      res.val = MidMinA[MidW-1:0];
      res.sat = 1'b1;
    end else begin
      res.val = r[MidW-1:0];
      res.sat = 1'b0;
    end
    return res;
  endfunction

  // Round half up, drop the fraction bits and saturate to the output width.
  function automatic out_sat_t round_sat_out(sum_b_t s, int unsigned frac);
    sum_b_t   half;
    sum_b_t   r;
    out_sat_t res;
    half = sum_b_t'(1) <<< (frac - 1);
    r    = (s + half) >>> frac;
    if (r > OutMaxB) begin
      res.val = OutMaxB[OutW-1:0];
      res.sat = 1'b1;
    end else if (r < OutMinB) begin
      res.val = OutMinB[OutW-1:0];
      res.sat = 1'b1;
    end else begin
      res.val = r[OutW-1:0];
      res.sat = 1'b0;
    end
    return res;
  endfunction

endpackage

// ===== src/qvr_mul_a.sv =====
module qvr_mul_a (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  qvr_pkg::quat_t    rot_i,
  input  qvr_pkg::vec_t     vec_i,
  output logic              valid_o,
  input  logic              ready_i,
  output qvr_pkg::prod_a_t  prod_o [qvr_pkg::NumProd],
  output qvr_pkg::quat_t    rot_o
);

  logic             valid_q;
  qvr_pkg::prod_a_t prod_q [qvr_pkg::NumProd];
  qvr_pkg::quat_t   rot_q;

  // The stage takes a beat when it is empty or its content moves on.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Partial products of q * (v, 0), grouped by result part x, y, z, w.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      prod_q[0]  <= qvr_pkg::prod_a_t'(rot_i.y) * qvr_pkg::prod_a_t'(vec_i.z);
      prod_q[1]  <= qvr_pkg::prod_a_t'(rot_i.z) * qvr_pkg::prod_a_t'(vec_i.y);
      prod_q[2]  <= qvr_pkg::prod_a_t'(rot_i.w) * qvr_pkg::prod_a_t'(vec_i.x);
      prod_q[3]  <= qvr_pkg::prod_a_t'(rot_i.x) * qvr_pkg::prod_a_t'(vec_i.z);
      prod_q[4]  <= qvr_pkg::prod_a_t'(rot_i.z) * qvr_pkg::prod_a_t'(vec_i.x);
      prod_q[5]  <= qvr_pkg::prod_a_t'(rot_i.w) * qvr_pkg::prod_a_t'(vec_i.y);
      prod_q[6]  <= qvr_pkg::prod_a_t'(rot_i.x) * qvr_pkg::prod_a_t'(vec_i.y);
      prod_q[7]  <= qvr_pkg::prod_a_t'(rot_i.y) * qvr_pkg::prod_a_t'(vec_i.x);
      prod_q[8]  <= qvr_pkg::prod_a_t'(rot_i.w) * qvr_pkg::prod_a_t'(vec_i.z);
      prod_q[9]  <= qvr_pkg::prod_a_t'(rot_i.x) * qvr_pkg::prod_a_t'(vec_i.x);
      prod_q[10] <= qvr_pkg::prod_a_t'(rot_i.y) * qvr_pkg::prod_a_t'(vec_i.y);
      prod_q[11] <= qvr_pkg::prod_a_t'(rot_i.z) * qvr_pkg::prod_a_t'(vec_i.z);
      rot_q      <= rot_i;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;
  assign rot_o   = rot_q;

endmodule

// ===== src/qvr_sum_a.sv =====
module qvr_sum_a #(
  parameter int unsigned FracBits = qvr_pkg::FracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  qvr_pkg::prod_a_t    prod_i [qvr_pkg::NumProd],
  input  qvr_pkg::quat_t      rot_i,
  output logic                valid_o,
  input  logic                ready_i,
  output qvr_pkg::mid_quat_t  mid_o,
  output logic                sat_o,
  output qvr_pkg::quat_t      rot_o
);

  logic               valid_q;
  qvr_pkg::mid_quat_t mid_q;
  logic               sat_q;
  qvr_pkg::quat_t     rot_q;

  qvr_pkg::sum_a_t    sum_x, sum_y, sum_z, sum_w;
  qvr_pkg::mid_sat_t  rnd_x, rnd_y, rnd_z, rnd_w;

  assign ready_o = !valid_q || ready_i;

  // Signed sums of the first product, extended before adding, then rounding and middle saturation.
  always_comb begin
    sum_x = qvr_pkg::sum_a_t'(prod_i[0]) - qvr_pkg::sum_a_t'(prod_i[1])
          + qvr_pkg::sum_a_t'(prod_i[2]);
    sum_y = qvr_pkg::sum_a_t'(prod_i[4]) + qvr_pkg::sum_a_t'(prod_i[5])
          - qvr_pkg::sum_a_t'(prod_i[3]);
    sum_z = qvr_pkg::sum_a_t'(prod_i[6]) - qvr_pkg::sum_a_t'(prod_i[7])
          + qvr_pkg::sum_a_t'(prod_i[8]);
    sum_w = -qvr_pkg::sum_a_t'(prod_i[9]) - qvr_pkg::sum_a_t'(prod_i[10])
          - qvr_pkg::sum_a_t'(prod_i[11]);
    rnd_x = qvr_pkg::round_sat_mid(sum_x, FracBits);
    rnd_y = qvr_pkg::round_sat_mid(sum_y, FracBits);
    rnd_z = qvr_pkg::round_sat_mid(sum_z, FracBits);
    rnd_w = qvr_pkg::round_sat_mid(sum_w, FracBits);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Rounded middle quaternion and its saturation flag.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      mid_q.x <= rnd_x.val;
      mid_q.y <= rnd_y.val;
      mid_q.z <= rnd_z.val;
      mid_q.w <= rnd_w.val;
      sat_q   <= rnd_x.sat | rnd_y.sat | rnd_z.sat | rnd_w.sat;
      rot_q   <= rot_i;
    end
  end

  assign valid_o = valid_q;
  assign mid_o   = mid_q;
  assign sat_o   = sat_q;
  assign rot_o   = rot_q;

endmodule

// ===== src/qvr_mul_b.sv =====
module qvr_mul_b (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  qvr_pkg::mid_quat_t  mid_i,
  input  logic                sat_i,
  input  qvr_pkg::quat_t      rot_i,
  output logic                valid_o,
  input  logic                ready_i,
  output qvr_pkg::prod_b_t    prod_o [qvr_pkg::NumProd],
  output logic                sat_o
);

  logic             valid_q;
  qvr_pkg::prod_b_t prod_q [qvr_pkg::NumProd];
  logic             sat_q;

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Partial products of p * conj(q); the conjugate signs are applied in the sums.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      prod_q[0]  <= qvr_pkg::prod_b_t'(mid_i.x) * qvr_pkg::prod_b_t'(rot_i.w);
      prod_q[1]  <= qvr_pkg::prod_b_t'(mid_i.y) * qvr_pkg::prod_b_t'(rot_i.z);
      prod_q[2]  <= qvr_pkg::prod_b_t'(mid_i.z) * qvr_pkg::prod_b_t'(rot_i.y);
      prod_q[3]  <= qvr_pkg::prod_b_t'(mid_i.w) * qvr_pkg::prod_b_t'(rot_i.x);
      prod_q[4]  <= qvr_pkg::prod_b_t'(mid_i.x) * qvr_pkg::prod_b_t'(rot_i.z);
      prod_q[5]  <= qvr_pkg::prod_b_t'(mid_i.y) * qvr_pkg::prod_b_t'(rot_i.w);
      prod_q[6]  <= qvr_pkg::prod_b_t'(mid_i.z) * qvr_pkg::prod_b_t'(rot_i.x);
      prod_q[7]  <= qvr_pkg::prod_b_t'(mid_i.w) * qvr_pkg::prod_b_t'(rot_i.y);
      prod_q[8]  <= qvr_pkg::prod_b_t'(mid_i.x) * qvr_pkg::prod_b_t'(rot_i.y);
      prod_q[9]  <= qvr_pkg::prod_b_t'(mid_i.y) * qvr_pkg::prod_b_t'(rot_i.x);
      prod_q[10] <= qvr_pkg::prod_b_t'(mid_i.z) * qvr_pkg::prod_b_t'(rot_i.w);
      prod_q[11] <= qvr_pkg::prod_b_t'(mid_i.w) * qvr_pkg::prod_b_t'(rot_i.z);
      sat_q      <= sat_i;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;
  assign sat_o   = sat_q;

endmodule

// ===== src/qvr_sum_b.sv =====
module qvr_sum_b #(
  parameter int unsigned FracBits = qvr_pkg::FracBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  qvr_pkg::prod_b_t  prod_i [qvr_pkg::NumProd],
  input  logic              sat_i,
  output logic              valid_o,
  input  logic              ready_i,
  output qvr_pkg::res_t     res_o,
  output logic              clipped_o
);

  logic              valid_q;
  qvr_pkg::res_t     res_q;
  logic              clipped_q;

  qvr_pkg::sum_b_t   sum_x, sum_y, sum_z;
  qvr_pkg::out_sat_t rnd_x, rnd_y, rnd_z;

  assign ready_o = !valid_q || ready_i;

  // Signed sums of the second product, then rounding and output saturation.
  always_comb begin
    sum_x = qvr_pkg::sum_b_t'(prod_i[0]) - qvr_pkg::sum_b_t'(prod_i[1])
          + qvr_pkg::sum_b_t'(prod_i[2]) - qvr_pkg::sum_b_t'(prod_i[3]);
    sum_y = qvr_pkg::sum_b_t'(prod_i[4]) + qvr_pkg::sum_b_t'(prod_i[5])
          - qvr_pkg::sum_b_t'(prod_i[6]) - qvr_pkg::sum_b_t'(prod_i[7]);
    sum_z = qvr_pkg::sum_b_t'(prod_i[9]) + qvr_pkg::sum_b_t'(prod_i[10])
          - qvr_pkg::sum_b_t'(prod_i[8]) - qvr_pkg::sum_b_t'(prod_i[11]);
    rnd_x = qvr_pkg::round_sat_out(sum_x, FracBits);
    rnd_y = qvr_pkg::round_sat_out(sum_y, FracBits);
    rnd_z = qvr_pkg::round_sat_out(sum_z, FracBits);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Output register holding the result beat.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q.x   <= rnd_x.val;
      res_q.y   <= rnd_y.val;
      res_q.z   <= rnd_z.val;
      clipped_q <= sat_i | rnd_x.sat | rnd_y.sat | rnd_z.sat;
    end
  end

  assign valid_o   = valid_q;
  assign res_o     = res_q;
  assign clipped_o = clipped_q;

endmodule

// ===== src/quaternion_vector_rotate.sv =====
// Rotates a 16-bit integer vector by a fixed-point quaternion as q * (v,0) * conj(q)
// and returns the x, y and z parts, saturated to 16 bits, with a flag that is set
// when any intermediate or final part saturated. The datapath is a four-stage
// pipeline (first products, first sums, second products, second sums), and one beat
// can be accepted in every cycle unless in_stall_o is set. The last stage is the
// output register; a stall on the output fills empty stages first and reaches the
// input only once all four stages hold a beat.
module quaternion_vector_rotate #(
  parameter int unsigned FracBits = qvr_pkg::FracBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [15:0]   vec_x_i,
  input  logic signed [15:0]   vec_y_i,
  input  logic signed [15:0]   vec_z_i,
  input  logic signed [15:0]   rot_x_i,
  input  logic signed [15:0]   rot_y_i,
  input  logic signed [15:0]   rot_z_i,
  input  logic signed [15:0]   rot_w_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [15:0]   out_x_o,
  output logic signed [15:0]   out_y_o,
  output logic signed [15:0]   out_z_o,
  output logic                 clipped_o
);

  qvr_pkg::quat_t     rot_in;
  qvr_pkg::vec_t      vec_in;

  logic               a_valid, a_ready;
  qvr_pkg::prod_a_t   a_prod [qvr_pkg::NumProd];
  qvr_pkg::quat_t     a_rot;

  logic               b_valid, b_ready;
  qvr_pkg::mid_quat_t b_mid;
  logic               b_sat;
  qvr_pkg::quat_t     b_rot;

  logic               c_valid, c_ready;
  qvr_pkg::prod_b_t   c_prod [qvr_pkg::NumProd];
  logic               c_sat;

  logic               d_ready;
  qvr_pkg::res_t      d_res;

  // Input beat gathered into structs.
  assign rot_in = '{x: rot_x_i, y: rot_y_i, z: rot_z_i, w: rot_w_i};
  assign vec_in = '{x: vec_x_i, y: vec_y_i, z: vec_z_i};

  assign in_stall_o = !a_ready;

  qvr_mul_a u_mul_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (a_ready),
    .rot_i   (rot_in),
    .vec_i   (vec_in),
    .valid_o (a_valid),
    .ready_i (b_ready),
    .prod_o  (a_prod),
    .rot_o   (a_rot)
  );

  qvr_sum_a #(
    .FracBits (FracBits)
  ) u_sum_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (a_valid),
    .ready_o (b_ready),
    .prod_i  (a_prod),
    .rot_i   (a_rot),
    .valid_o (b_valid),
    .ready_i (c_ready),
    .mid_o   (b_mid),
    .sat_o   (b_sat),
    .rot_o   (b_rot)
  );

  qvr_mul_b u_mul_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (b_valid),
    .ready_o (c_ready),
    .mid_i   (b_mid),
    .sat_i   (b_sat),
    .rot_i   (b_rot),
    .valid_o (c_valid),
    .ready_i (d_ready),
    .prod_o  (c_prod),
    .sat_o   (c_sat)
  );

  qvr_sum_b #(
    .FracBits (FracBits)
  ) u_sum_b (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (c_valid),
    .ready_o   (d_ready),
    .prod_i    (c_prod),
    .sat_i     (c_sat),
    .valid_o   (out_valid_o),
    .ready_i   (!out_stall_i),
    .res_o     (d_res),
    .clipped_o (clipped_o)
  );

  assign out_x_o = d_res.x;
  assign out_y_o = d_res.y;
  assign out_z_o = d_res.z;

`ifndef NO_ASSERTIONS
  // The input can only be stalled when the whole pipeline is full and the output is held.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && a_valid && b_valid && c_valid))
    else $error("input stalled while the pipeline has room");

  // A held middle-stage beat is neither dropped nor altered.
  a_mid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid && !c_ready) |=> (b_valid && $stable(b_mid) && $stable(b_sat)))
    else $error("middle stage lost or changed a held beat");

  // A held second-product beat keeps its saturation flag.
  a_prod_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_valid && !d_ready) |=> (c_valid && $stable(c_sat)))
    else $error("second product stage lost a held beat");
`endif

endmodule
